FILE: design/sef_pkg.sv
// Package for the silhouette edge finder: shared widths, codes and the
// controller/datapath command and status structures. No dependencies.
`timescale 1ns / 1ps

package sef_pkg;

	localparam int MAX_VERTICES_DEF     = 1024;
	localparam int EDGES_PER_VERTEX_DEF = 32;

	localparam int VIDX_W  = 10;
	localparam int COORD_W = 24;
	localparam int LIGHT_W = 16;
	localparam int APB_AW  = 4;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_TRI   = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	localparam logic [1:0] KIND_FACE = 2'd0;
	localparam logic [1:0] KIND_EDGE = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [1:0] REG_LIGHT_X = 2'd0;
	localparam logic [1:0] REG_LIGHT_Y = 2'd1;
	localparam logic [1:0] REG_LIGHT_Z = 2'd2;

	// Count read selects.
	localparam logic [1:0] CSEL_A  = 2'd0;
	localparam logic [1:0] CSEL_B  = 2'd1;
	localparam logic [1:0] CSEL_C  = 2'd2;
	localparam logic [1:0] CSEL_TO = 2'd3;

	localparam logic [3:0] MSTEP_LAST = 4'd11;

	typedef struct packed {
		logic       accept;
		logic       pos_wr;
		logic       sweep_clr;
		logic       sweep_wr;
		logic       pos_rd;
		logic [1:0] pos_sel;
		logic       diff;
		logic       mul;
		logic       acc;
		logic [3:0] mstep;
		logic       cnt_rd;
		logic [1:0] cnt_sel;
		logic       edge_wr;
		logic [1:0] edge_sel;
		logic       qinit;
		logic       tbl_rd_j;
		logic       cap_e;
		logic       j_inc;
		logic       c2init;
		logic       tbl_rd_k;
		logic       emit;
		logic [1:0] kind;
	} cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic j_end;
		logic k_end;
		logic e_face;
		logic rmatch;
		logic face;
	} status_t;

endpackage

FILE: design/sef_ctrl.sv
// Controller state machine of the silhouette edge finder.
// Depends on sef_pkg; drives the command structure of sef_datapath.
`timescale 1ns / 1ps

module sef_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       op,
	input  sef_pkg::status_t st,
	output sef_pkg::cmd_t    cmd,
	output logic             busy
);
	import sef_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CLR    = 5'd1;
	localparam logic [4:0] S_T_RD   = 5'd2;
	localparam logic [4:0] S_T_WAIT = 5'd3;
	localparam logic [4:0] S_T_DIFF = 5'd4;
	localparam logic [4:0] S_T_MUL  = 5'd5;
	localparam logic [4:0] S_T_ACC  = 5'd6;
	localparam logic [4:0] S_T_ERD  = 5'd7;
	localparam logic [4:0] S_T_EWR  = 5'd8;
	localparam logic [4:0] S_T_EMIT = 5'd9;
	localparam logic [4:0] S_Q_CNT  = 5'd10;
	localparam logic [4:0] S_Q_INIT = 5'd11;
	localparam logic [4:0] S_Q_E    = 5'd12;
	localparam logic [4:0] S_Q_EW   = 5'd13;
	localparam logic [4:0] S_Q_EF   = 5'd14;
	localparam logic [4:0] S_Q_C2   = 5'd15;
	localparam logic [4:0] S_Q_R    = 5'd16;
	localparam logic [4:0] S_Q_OUT  = 5'd17;

	logic [4:0] state_q, state_d;
	logic [3:0] ctr_q, ctr_d;
	logic       rpend_q, rpend_d;
	logic       paired_q, paired_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		ctr_d    = ctr_q;
		rpend_d  = 1'b0;
		paired_d = paired_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					ctr_d      = '0;
					case (op)
						OP_CLEAR: begin
							cmd.sweep_clr = 1'b1;
							state_d       = S_CLR;
						end
						OP_LOAD:  cmd.pos_wr = 1'b1;
						OP_TRI:   state_d = S_T_RD;
						OP_QUERY: state_d = S_Q_CNT;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_CLR: begin
				cmd.sweep_wr = 1'b1;
				if (st.sweep_done) state_d = S_IDLE;
			end
			S_T_RD: begin
				cmd.pos_rd  = 1'b1;
				cmd.pos_sel = ctr_q[1:0];
				ctr_d       = ctr_q + 4'd1;
				if (ctr_q == 4'd2) begin
					state_d = S_T_WAIT;
				end
			end
			S_T_WAIT: state_d = S_T_DIFF;
			S_T_DIFF: begin
				cmd.diff = 1'b1;
				ctr_d    = '0;
				state_d  = S_T_MUL;
			end
			S_T_MUL: begin
				cmd.mul   = 1'b1;
				cmd.mstep = ctr_q;
				state_d   = S_T_ACC;
			end
			S_T_ACC: begin
				cmd.acc   = 1'b1;
				cmd.mstep = ctr_q;
				if (ctr_q == MSTEP_LAST) begin
					ctr_d   = '0;
					state_d = S_T_ERD;
				end else begin
					ctr_d   = ctr_q + 4'd1;
					state_d = S_T_MUL;
				end
			end
			S_T_ERD: begin
				cmd.cnt_rd  = 1'b1;
				cmd.cnt_sel = ctr_q[1:0];
				state_d     = S_T_EWR;
			end
			S_T_EWR: begin
				cmd.edge_wr  = 1'b1;
				cmd.edge_sel = ctr_q[1:0];
				ctr_d        = ctr_q + 4'd1;
				state_d      = (ctr_q == 4'd2) ? S_T_EMIT : S_T_ERD;
			end
			S_T_EMIT: begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_FACE;
				state_d  = S_IDLE;
			end
			S_Q_CNT: begin
				cmd.cnt_rd  = 1'b1;
				cmd.cnt_sel = CSEL_A;
				state_d     = S_Q_INIT;
			end
			S_Q_INIT: begin
				cmd.qinit = 1'b1;
				state_d   = S_Q_E;
			end
			S_Q_E: begin
				if (st.j_end) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_DONE;
					state_d  = S_IDLE;
				end else begin
					cmd.tbl_rd_j = 1'b1;
					state_d      = S_Q_EW;
				end
			end
			S_Q_EW: begin
				cmd.cap_e = 1'b1;
				state_d   = S_Q_EF;
			end
			S_Q_EF: begin
				if (st.e_face) begin
					cmd.cnt_rd  = 1'b1;
					cmd.cnt_sel = CSEL_TO;
					state_d     = S_Q_C2;
				end else begin
					cmd.j_inc = 1'b1;
					state_d   = S_Q_E;
				end
			end
			S_Q_C2: begin
				cmd.c2init = 1'b1;
				paired_d   = 1'b0;
				state_d    = S_Q_R;
			end
			S_Q_R: begin
				// Reverse-list reads stream one per cycle; a match is seen in the following cycle.
				if (rpend_q && st.rmatch) paired_d = 1'b1;
				if (!st.k_end) begin
					cmd.tbl_rd_k = 1'b1;
					rpend_d      = 1'b1;
				end else if (!rpend_q) begin
					state_d = S_Q_OUT;
				end
			end
			S_Q_OUT: begin
				cmd.j_inc = 1'b1;
				if (!paired_q) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_EDGE;
				end
				state_d = S_Q_E;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			ctr_q    <= '0;
			rpend_q  <= 1'b0;
			paired_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ctr_q    <= ctr_d;
			rpend_q  <= rpend_d;
			paired_q <= paired_d;
		end
	end

endmodule

FILE: design/sef_datapath.sv
// Datapath of the silhouette edge finder: position, count and edge memories,
// the shared multiplier with its accumulators, and the result registers.
// Depends on sef_pkg; steered by sef_ctrl.
`timescale 1ns / 1ps

module sef_datapath #(
	parameter int MAX_VERTICES     = sef_pkg::MAX_VERTICES_DEF,
	parameter int EDGES_PER_VERTEX = sef_pkg::EDGES_PER_VERTEX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sef_pkg::cmd_t                      cmd,
	output sef_pkg::status_t                   st,
	input  logic [sef_pkg::VIDX_W-1:0]         vertex_a,
	input  logic [sef_pkg::VIDX_W-1:0]         vertex_b,
	input  logic [sef_pkg::VIDX_W-1:0]         vertex_c,
	input  logic signed [sef_pkg::COORD_W-1:0] coord_x,
	input  logic signed [sef_pkg::COORD_W-1:0] coord_y,
	input  logic signed [sef_pkg::COORD_W-1:0] coord_z,
	input  logic signed [sef_pkg::LIGHT_W-1:0] light_x,
	input  logic signed [sef_pkg::LIGHT_W-1:0] light_y,
	input  logic signed [sef_pkg::LIGHT_W-1:0] light_z,
	output logic                               strobe,
	output logic [1:0]                         kind,
	output logic [sef_pkg::VIDX_W-1:0]         edge_from,
	output logic [sef_pkg::VIDX_W-1:0]         edge_to,
	output logic                               faces_light,
	output logic                               last
);
	import sef_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int SW = $clog2(EDGES_PER_VERTEX);
	localparam int CW = $clog2(EDGES_PER_VERTEX + 1);
	localparam int TD = MAX_VERTICES * (1 << SW);
	localparam int EW = VIDX_W + 1;

	function automatic logic [AW-1:0] vidx(input logic [VIDX_W-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[AW-1:0];
	endfunction

	function automatic logic in_rng(input logic [VIDX_W-1:0] v);
		return 32'(v) < 32'(MAX_VERTICES);
	endfunction

	logic signed [COORD_W-1:0] pos_x_mem [MAX_VERTICES];
	logic signed [COORD_W-1:0] pos_y_mem [MAX_VERTICES];
	logic signed [COORD_W-1:0] pos_z_mem [MAX_VERTICES];
	logic [CW-1:0]             cnt_mem   [MAX_VERTICES];
	logic [EW-1:0]             tbl_mem   [TD];

	logic [VIDX_W-1:0] va_q, vb_q, vc_q;
	logic [AW-1:0]     sweep_addr_q;

	logic signed [COORD_W-1:0] prx_q, pry_q, prz_q;
	logic                      pos_v_q, pos_ok_q;
	logic [1:0]                pos_sel_q;
	logic [VIDX_W-1:0]         pos_addr;

	logic signed [COORD_W-1:0] p1x_q, p1y_q, p1z_q, p2x_q, p2y_q, p2z_q, p3x_q, p3y_q, p3z_q;
	logic signed [COORD_W:0]   d1x_q, d1y_q, d1z_q, d2x_q, d2y_q, d2z_q;

	logic signed [31:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [56:0] ea, eb, p_q;
	logic signed [51:0] ntmp_q, nx_q, ny_q, nz_q;
	logic signed [71:0] dacc_q;

	logic [CW-1:0]     cnt_q, qcount_q, c2_q, j_q, k_q, cntv;
	logic              cnt_ok_q;
	logic [VIDX_W-1:0] cnt_addr;
	logic [EW-1:0]     tbl_q, e_q;
	logic [AW+SW-1:0]  tbl_raddr;

	logic [VIDX_W-1:0] ef, et;

	// Input capture.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			va_q <= vertex_a;
			vb_q <= vertex_b;
			vc_q <= vertex_c;
		end
	end

	// Position memories.
	always_comb begin
		case (cmd.pos_sel)
			2'd0:    pos_addr = va_q;
			2'd1:    pos_addr = vb_q;
			default: pos_addr = vc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_wr && in_rng(vertex_a)) begin
			pos_x_mem[vidx(vertex_a)] <= coord_x;
			pos_y_mem[vidx(vertex_a)] <= coord_y;
			pos_z_mem[vidx(vertex_a)] <= coord_z;
		end
		if (cmd.pos_rd) begin
			prx_q <= pos_x_mem[vidx(pos_addr)];
			pry_q <= pos_y_mem[vidx(pos_addr)];
			prz_q <= pos_z_mem[vidx(pos_addr)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_v_q <= 1'b0;
		end else begin
			pos_v_q <= cmd.pos_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pos_rd) begin
			pos_sel_q <= cmd.pos_sel;
			pos_ok_q  <= in_rng(pos_addr);
		end
		// A corner beyond the store reads as the origin.
		if (pos_v_q) begin
			case (pos_sel_q)
				2'd0: begin
					p1x_q <= pos_ok_q ? prx_q : '0;
					p1y_q <= pos_ok_q ? pry_q : '0;
					p1z_q <= pos_ok_q ? prz_q : '0;
				end
				2'd1: begin
					p2x_q <= pos_ok_q ? prx_q : '0;
					p2y_q <= pos_ok_q ? pry_q : '0;
					p2z_q <= pos_ok_q ? prz_q : '0;
				end
				default: begin
					p3x_q <= pos_ok_q ? prx_q : '0;
					p3y_q <= pos_ok_q ? pry_q : '0;
					p3z_q <= pos_ok_q ? prz_q : '0;
				end
			endcase
		end
		if (cmd.diff) begin
			d1x_q <= 25'(p2x_q) - 25'(p1x_q);
			d1y_q <= 25'(p2y_q) - 25'(p1y_q);
			d1z_q <= 25'(p2z_q) - 25'(p1z_q);
			d2x_q <= 25'(p3x_q) - 25'(p1x_q);
			d2y_q <= 25'(p3y_q) - 25'(p1y_q);
			d2z_q <= 25'(p3z_q) - 25'(p1z_q);
		end
	end

	// Shared multiplier: six cross-product terms, then the exact dot product
	// with each normal component split into a signed high part and a 20-bit low part.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mstep)
			4'd0: begin mul_a = 32'(d1y_q); mul_b = d2z_q; end
			4'd1: begin mul_a = 32'(d1z_q); mul_b = d2y_q; end
			4'd2: begin mul_a = 32'(d1z_q); mul_b = d2x_q; end
			4'd3: begin mul_a = 32'(d1x_q); mul_b = d2z_q; end
			4'd4: begin mul_a = 32'(d1x_q); mul_b = d2y_q; end
			4'd5: begin mul_a = 32'(d1y_q); mul_b = d2x_q; end
			4'd6: begin mul_a = $signed(nx_q[51:20]);         mul_b = 25'(light_x); end
			4'd7: begin mul_a = $signed({12'd0, nx_q[19:0]}); mul_b = 25'(light_x); end
			4'd8: begin mul_a = $signed(ny_q[51:20]);         mul_b = 25'(light_y); end
			4'd9: begin mul_a = $signed({12'd0, ny_q[19:0]}); mul_b = 25'(light_y); end
			4'd10: begin mul_a = $signed(nz_q[51:20]);         mul_b = 25'(light_z); end
			4'd11: begin mul_a = $signed({12'd0, nz_q[19:0]}); mul_b = 25'(light_z); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign ea = 57'(mul_a);
	assign eb = 57'(mul_b);

	always_ff @(posedge clk) begin
		if (cmd.mul) p_q <= ea * eb;
		if (cmd.acc) begin
			case (cmd.mstep)
				4'd0, 4'd2, 4'd4: ntmp_q <= $signed(p_q[51:0]);
				4'd1: nx_q <= ntmp_q - $signed(p_q[51:0]);
				4'd3: ny_q <= ntmp_q - $signed(p_q[51:0]);
				4'd5: nz_q <= ntmp_q - $signed(p_q[51:0]);
				4'd6, 4'd8, 4'd10: dacc_q <= dacc_q + (72'(p_q) <<< 20);
				4'd7, 4'd9, 4'd11: dacc_q <= dacc_q + 72'(p_q);
				default: dacc_q <= dacc_q;
			endcase
		end else if (cmd.diff) begin
			dacc_q <= '0;
		end
	end

	// Count memory: cleared by a sweep, one vertex per cycle.
	always_comb begin
		case (cmd.cnt_sel)
			CSEL_A:  cnt_addr = va_q;
			CSEL_B:  cnt_addr = vb_q;
			CSEL_C:  cnt_addr = vc_q;
			default: cnt_addr = e_q[VIDX_W-1:0];
		endcase
	end

	always_comb begin
		case (cmd.edge_sel)
			2'd0:    begin ef = va_q; et = vb_q; end
			2'd1:    begin ef = vb_q; et = vc_q; end
			default: begin ef = vc_q; et = va_q; end
		endcase
	end

	assign cntv = cnt_ok_q ? cnt_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
		end else if (cmd.sweep_clr) begin
			sweep_addr_q <= '0;
		end else if (cmd.sweep_wr) begin
			sweep_addr_q <= sweep_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_wr) begin
			cnt_mem[sweep_addr_q] <= '0;
		end else if (cmd.edge_wr && cnt_ok_q && (cnt_q < CW'(EDGES_PER_VERTEX))) begin
			cnt_mem[vidx(ef)] <= CW'(cnt_q + 1'b1);
		end
		if (cmd.cnt_rd) begin
			cnt_q    <= cnt_mem[vidx(cnt_addr)];
			cnt_ok_q <= in_rng(cnt_addr);
		end
	end

	// Edge table, one row of slots per start vertex.
	assign tbl_raddr = cmd.tbl_rd_k ? {vidx(e_q[VIDX_W-1:0]), k_q[SW-1:0]}
	                                : {vidx(va_q), j_q[SW-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.edge_wr && cnt_ok_q && (cnt_q < CW'(EDGES_PER_VERTEX))) begin
			tbl_mem[{vidx(ef), cnt_q[SW-1:0]}] <= {st.face, et};
		end
		if (cmd.tbl_rd_j || cmd.tbl_rd_k) begin
			tbl_q <= tbl_mem[tbl_raddr];
		end
		if (cmd.cap_e) e_q <= tbl_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q      <= '0;
			k_q      <= '0;
			qcount_q <= '0;
			c2_q     <= '0;
		end else begin
			if (cmd.qinit) begin
				qcount_q <= cntv;
				j_q      <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + 1'b1;
			end
			if (cmd.c2init) begin
				c2_q <= cntv;
				k_q  <= '0;
			end else if (cmd.tbl_rd_k) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	assign st.sweep_done = (sweep_addr_q == AW'(MAX_VERTICES - 1));
	assign st.j_end      = (j_q == qcount_q);
	assign st.k_end      = (k_q == c2_q);
	assign st.e_face     = e_q[VIDX_W];
	assign st.rmatch     = tbl_q[VIDX_W] && (tbl_q[VIDX_W-1:0] == va_q);
	assign st.face       = (dacc_q > 72'sd0);

	// Result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind        <= cmd.kind;
			faces_light <= (cmd.kind == KIND_FACE) ? st.face : 1'b0;
			last        <= (cmd.kind != KIND_EDGE);
			edge_from   <= (cmd.kind == KIND_FACE) ? '0 : va_q;
			edge_to     <= (cmd.kind == KIND_EDGE) ? e_q[VIDX_W-1:0] : '0;
		end
	end

endmodule

FILE: design/silhouette_edge_finder_top.sv
// Top level of the silhouette edge finder: light registers on the APB port,
// controller and datapath. Depends on sef_pkg, sef_ctrl and sef_datapath.
`timescale 1ns / 1ps

// The block takes one command transaction when start is high and busy is low,
// and returns results as one-cycle strobes that the receiver must take at once.
// A vertex load completes in the accept cycle and busy stays low. A triangle
// performs three position reads, six cross-product terms and six dot-product
// terms through one shared 32x25 multiplier, then appends its edges; it
// returns one facing report. A query walks the queried list and, for each
// facing edge, its reverse list, reading each reverse list from the one-port
// edge table one entry per cycle; lists hold 32 entries by default. A clear,
// and reset, sweep the per-vertex edge counts one vertex per cycle, busy high.
// Light registers are at bytes 0, 4, 8; the user may change them only while
// busy is low and no result is outstanding; the block does not enforce it.
module silhouette_edge_finder_top #(
	parameter int MAX_VERTICES     = sef_pkg::MAX_VERTICES_DEF,
	parameter int EDGES_PER_VERTEX = sef_pkg::EDGES_PER_VERTEX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sef_pkg::APB_AW-1:0]         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         op,
	input  logic [sef_pkg::VIDX_W-1:0]         vertex_a,
	input  logic [sef_pkg::VIDX_W-1:0]         vertex_b,
	input  logic [sef_pkg::VIDX_W-1:0]         vertex_c,
	input  logic signed [sef_pkg::COORD_W-1:0] coord_x,
	input  logic signed [sef_pkg::COORD_W-1:0] coord_y,
	input  logic signed [sef_pkg::COORD_W-1:0] coord_z,
	output logic                               strobe,
	output logic [1:0]                         kind,
	output logic [sef_pkg::VIDX_W-1:0]         edge_from,
	output logic [sef_pkg::VIDX_W-1:0]         edge_to,
	output logic                               faces_light,
	output logic                               last
);
	import sef_pkg::*;

	logic signed [LIGHT_W-1:0] light_x_q, light_y_q, light_z_q;
	logic                      cfg_wr;
	cmd_t                      cmd;
	status_t                   st;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// The light defaults to straight along +z.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q <= '0;
			light_y_q <= '0;
			light_z_q <= 16'sh7FFF;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LIGHT_X: light_x_q <= pwdata[LIGHT_W-1:0];
				REG_LIGHT_Y: light_y_q <= pwdata[LIGHT_W-1:0];
				REG_LIGHT_Z: light_z_q <= pwdata[LIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LIGHT_X: prdata = {16'd0, light_x_q};
			REG_LIGHT_Y: prdata = {16'd0, light_y_q};
			REG_LIGHT_Z: prdata = {16'd0, light_z_q};
			default:     prdata = '0;
		endcase
	end

	sef_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	sef_datapath #(
		.MAX_VERTICES     (MAX_VERTICES),
		.EDGES_PER_VERTEX (EDGES_PER_VERTEX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.vertex_a    (vertex_a),
		.vertex_b    (vertex_b),
		.vertex_c    (vertex_c),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.light_x     (light_x_q),
		.light_y     (light_y_q),
		.light_z     (light_z_q),
		.strobe      (strobe),
		.kind        (kind),
		.edge_from   (edge_from),
		.edge_to     (edge_to),
		.faces_light (faces_light),
		.last        (last)
	);

endmodule

FILE: design/sef_checker.sv
// Port-level checker for the silhouette edge finder, bound to the top level.
// Depends on sef_pkg.
`timescale 1ns / 1ps

module sef_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] op,
	input logic       strobe,
	input logic [1:0] kind,
	input logic       last
);
	import sef_pkg::*;

	// No command produces a result in the cycle right after it is taken.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !strobe) else $error("result right after accept");

	// Every command but a load keeps the block busy afterwards.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op != OP_LOAD) |=> busy) else $error("not busy after command");

	// An edge result is never the final one and more work follows it.
	a_edge_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_EDGE) |-> !last) else $error("edge marked last");

	a_busy_after_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> busy) else $error("idle with results pending");

	// The final result of a transaction is not followed by another at once.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe) else $error("result after last");

endmodule

bind silhouette_edge_finder_top sef_checker u_sef_checker (.*);
